@@ rtl/core/mesh_tangent_accumulator_defines.svh @@
// Assertion macros shared by the tangent accumulator RTL.
`ifndef MESH_TANGENT_ACCUMULATOR_DEFINES_SVH
`define MESH_TANGENT_ACCUMULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define MTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mta check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define MTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mta check failed");
`else
`define MTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/mta_pkg.sv @@
// Shared types and constants of the mesh tangent accumulator.
package mta_pkg;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam int FLD_W    = 16;
  localparam int EDGE_W   = 17;
  localparam int T_W      = 36;
  localparam int DOT_W    = 43;
  localparam int VEC_W    = 32;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 66;
  localparam int SQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int QUO_W    = 15;
  localparam int Q14_ONE  = 16384;

  typedef struct packed {
    logic signed [FLD_W-1:0] pos_x;
    logic signed [FLD_W-1:0] pos_y;
    logic signed [FLD_W-1:0] pos_z;
    logic signed [FLD_W-1:0] nrm_x;
    logic signed [FLD_W-1:0] nrm_y;
    logic signed [FLD_W-1:0] nrm_z;
    logic signed [FLD_W-1:0] tex_u;
    logic signed [FLD_W-1:0] tex_v;
  } vtx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TA, S_TB, S_TC, S_TD,
    S_PA, S_PB, S_PC, S_SHIFT,
    S_S3, S_S3E, S_SQS, S_SQW, S_DVS, S_DVW,
    S_FIN, S_ARD, S_AWR, S_RRD, S_RLD, S_OUT
  } st_t;

endpackage

@@ rtl/core/mta_mul.sv @@
// Shared signed multiplier with a registered product.
module mta_mul
  import mta_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

@@ rtl/core/mta_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module mta_sqrt
  import mta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

@@ rtl/core/mta_div.sv @@
// Restoring divider: rounded magnitude times 2^14 over the length, signed result.
module mta_div
  import mta_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VEC_W-1:0]        mag,
  input  logic                    neg,
  input  logic [ROOT_W-1:0]       len,
  output logic                    done,
  output logic signed [FLD_W-1:0] quot
);

  localparam int NUM_W = VEC_W + 14 + 1;

  logic [NUM_W-1:0]  num;
  logic [ROOT_W:0]   rem_r;
  logic [QUO_W-1:0]  low_r;
  logic [QUO_W-1:0]  q_r;
  logic [ROOT_W-1:0] len_r;
  logic              neg_r;
  logic [3:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W:0]   r2;
  logic [QUO_W-1:0]  qc;

  assign num = {1'b0, mag, 14'b0} + NUM_W'(len >> 1);
  assign r2  = {rem_r[ROOT_W-1:0], low_r[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (ROOT_W+1)'(num >> QUO_W);
      low_r <= num[QUO_W-1:0];
      q_r   <= '0;
      len_r <= len;
      neg_r <= neg;
    end else if (busy_r) begin
      low_r <= low_r << 1;
      if (r2 >= {1'b0, len_r}) begin
        rem_r <= r2 - {1'b0, len_r};
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= r2;
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  // The quotient never passes one, but the clamp keeps the Q2.14 range safe.
  assign qc   = (q_r > QUO_W'(Q14_ONE)) ? QUO_W'(Q14_ONE) : q_r;
  assign quot = neg_r ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  assign done = done_r;

endmodule

@@ rtl/core/mesh_tangent_accumulator.sv @@
// Top level of the mesh tangent accumulator: vertex and sum memories and the sequencer.
//
// The block keeps VERTEX_SLOTS vertex records and one saturating tangent sum per slot. A
// load transfer writes a vertex and clears its sum in the cycle it is accepted. A triangle
// transfer reads its three corners one after another from the vertex memory, then a
// sequencer drives one shared 33x33 multiplier through the UV determinant sign, the edge
// combination, the normal projection and the squared length, a 32-step square root unit
// and a 15-step divider per component, and finally read-modify-writes the three sums.
// After its transfer a triangle holds in_ready low until its sums are written; the
// pre-normalization shift runs one bit per cycle, and the root and divider are skipped
// when the tangent is zero. A read holds it low while its sum is normalized (the root
// and divider are skipped for a zero sum) and while its result waits for the output
// register to free up; a load leaves it high. Only one item is in flight, so in_ready is
// high only while the sequencer is idle, but a finished read result sits in its own output
// register and does not hold off the next transfer. Reading or using a slot that was
// never loaded gives undefined data; the memories are not cleared after reset.
`include "mesh_tangent_accumulator_defines.svh"
module mesh_tangent_accumulator
  import mta_pkg::*;
#(
  parameter int VERTEX_SLOTS = 1024,
  parameter int SUM_WIDTH    = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic [9:0]              in_corner_a,
  input  logic [9:0]              in_corner_b,
  input  logic [9:0]              in_corner_c,
  input  logic signed [15:0]      in_pos_x,
  input  logic signed [15:0]      in_pos_y,
  input  logic signed [15:0]      in_pos_z,
  input  logic signed [15:0]      in_nrm_x,
  input  logic signed [15:0]      in_nrm_y,
  input  logic signed [15:0]      in_nrm_z,
  input  logic signed [15:0]      in_tex_u,
  input  logic signed [15:0]      in_tex_v,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [9:0]              out_slot_read,
  output logic signed [15:0]      out_tan_x,
  output logic signed [15:0]      out_tan_y,
  output logic signed [15:0]      out_tan_z
);

  localparam int SLOT_W = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
  localparam int MOD_W  = 28;
  localparam int SROW_W = 3 * SUM_WIDTH;

  // Slot number modulo the slot count, by restoring compare and subtract.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [9:0] raw);
    logic [MOD_W-1:0] r;
    r = MOD_W'(raw);
    for (int k = 9; k >= 0; k--) begin
      if (r >= (MOD_W'(VERTEX_SLOTS) << k)) begin
        r = r - (MOD_W'(VERTEX_SLOTS) << k);
      end
    end
    return r[SLOT_W-1:0];
  endfunction

  // Add a Q2.14 component to a sum, clamping at the signed range of the sum.
  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] s,
    input logic signed [FLD_W-1:0]     d
  );
    logic signed [SUM_WIDTH:0] r;
    r = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(d);
    if (r[SUM_WIDTH] != r[SUM_WIDTH-1]) begin
      return r[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return r[SUM_WIDTH-1:0];
  endfunction

  // Control state.
  st_t        state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       sq_mode_r, sq_mode_nxt;
  logic       is_read_r, is_read_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;
  logic       out_free;

  // Corner slots.
  logic [SLOT_W-1:0] a_r, b_r, c_r;
  logic [SLOT_W-1:0] corner;

  // Memories.
  vtx_t              vmem [VERTEX_SLOTS];
  logic [SROW_W-1:0] smem [VERTEX_SLOTS];
  vtx_t              vrd_r;
  logic [SROW_W-1:0] srd_r;
  logic [SLOT_W-1:0] vaddr, saddr;
  logic              swe;
  logic [SROW_W-1:0] swdata;
  vtx_t              vwdata;

  // Datapath registers.
  logic signed [FLD_W-1:0]  pa_r [3];
  logic signed [FLD_W-1:0]  na_r [3];
  logic signed [FLD_W-1:0]  tua_r, tva_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [EDGE_W-1:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [T_W-1:0]    t_r [3];
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [VEC_W-1:0]  vec_r [3];
  logic signed [FLD_W-1:0]  o_r [3];
  logic signed [PROD_W-1:0] acc_r;
  logic                     neg_r;
  logic [SQ_W-1:0]          sq_r;
  logic [ROOT_W-1:0]        len_r;
  logic [9:0]               out_slot_r;
  logic signed [FLD_W-1:0]  out_tan_r [3];

  // Shared units.
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic                     sq_start, sq_done;
  logic [ROOT_W-1:0]        sq_root;
  logic                     dv_start, dv_done;
  logic signed [FLD_W-1:0]  dv_quot;
  logic [VEC_W-1:0]         dv_mag;
  logic                     dv_neg;

  // Combination helpers.
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] proj;
  logic signed [PROD_W-1:0] proj_rnd;
  logic signed [PROD_W-1:0] total;
  logic [1:0]               kp;
  logic                     t_big;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Component index for the edge phases (1..3) and the projection phases (4..6).
  always_comb begin
    kp = 2'd0;
    case (ph_r)
      3'd1, 3'd4: kp = 2'd0;
      3'd2, 3'd5: kp = 2'd1;
      3'd3, 3'd6: kp = 2'd2;
      default:    kp = 2'd0;
    endcase
  end

  always_comb begin
    case (cnt_r)
      2'd0:    corner = a_r;
      2'd1:    corner = b_r;
      default: corner = c_r;
    endcase
  end

  assign diff     = acc_r - prod;
  assign proj     = acc_r + (prod <<< 22);
  assign proj_rnd = (proj + PROD_W'(64'sd134217728)) >>> 28;
  assign total    = acc_r + prod;
  assign t_big    = (t_r[0] >= 36'sd16777216) || (t_r[0] <= -36'sd16777216) ||
                    (t_r[1] >= 36'sd16777216) || (t_r[1] <= -36'sd16777216) ||
                    (t_r[2] >= 36'sd16777216) || (t_r[2] <= -36'sd16777216);

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_PA: begin
        if (ph_r == 3'd0) begin
          op_a = MUL_W'(du1_r);
          op_b = MUL_W'(dv2_r);
        end else if (ph_r <= 3'd3) begin
          op_a = MUL_W'(e1_r[kp]);
          op_b = MUL_W'(dv2_r);
        end else begin
          op_a = MUL_W'(na_r[kp]);
          op_b = $signed({11'b0, dot_r[21:0]});
        end
      end
      S_PB: begin
        if (ph_r == 3'd0) begin
          op_a = MUL_W'(du2_r);
          op_b = MUL_W'(dv1_r);
        end else if (ph_r <= 3'd3) begin
          op_a = MUL_W'(e2_r[kp]);
          op_b = MUL_W'(dv1_r);
        end else begin
          op_a = MUL_W'(na_r[kp]);
          op_b = MUL_W'($signed(dot_r[DOT_W-1:22]));
        end
      end
      S_S3: begin
        if (sq_mode_r) begin
          op_a = MUL_W'(vec_r[cnt_r]);
          op_b = MUL_W'(vec_r[cnt_r]);
        end else begin
          op_a = MUL_W'($signed(t_r[cnt_r][24:0]));
          op_b = MUL_W'(na_r[cnt_r]);
        end
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    cnt_nxt       = cnt_r;
    sq_mode_nxt   = sq_mode_r;
    is_read_nxt   = is_read_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sq_start      = 1'b0;
    dv_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_action == ACT_TRI) begin
            state_nxt   = S_TA;
            is_read_nxt = 1'b0;
          end else if (in_action == ACT_READ) begin
            state_nxt   = S_RRD;
            is_read_nxt = 1'b1;
          end
        end
      end
      S_TA: state_nxt = S_TB;
      S_TB: state_nxt = S_TC;
      S_TC: state_nxt = S_TD;
      S_TD: begin
        state_nxt = S_PA;
        ph_nxt    = 3'd0;
      end
      S_PA: state_nxt = S_PB;
      S_PB: state_nxt = S_PC;
      S_PC: begin
        if (ph_r == 3'd3) begin
          state_nxt = S_SHIFT;
        end else if (ph_r == 3'd6) begin
          state_nxt   = S_S3;
          sq_mode_nxt = 1'b1;
          cnt_nxt     = 2'd0;
        end else begin
          state_nxt = S_PA;
          ph_nxt    = ph_r + 3'd1;
        end
      end
      S_SHIFT: begin
        if (!t_big) begin
          state_nxt   = S_S3;
          sq_mode_nxt = 1'b0;
          cnt_nxt     = 2'd0;
        end
      end
      S_S3: begin
        if (cnt_r == 2'd2) begin
          state_nxt = S_S3E;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_S3E: begin
        if (!sq_mode_r) begin
          state_nxt = S_PA;
          ph_nxt    = 3'd4;
        end else if (total == '0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SQS;
        end
      end
      S_SQS: begin
        sq_start  = 1'b1;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (sq_done) begin
          state_nxt = S_DVS;
          cnt_nxt   = 2'd0;
        end
      end
      S_DVS: begin
        dv_start  = 1'b1;
        state_nxt = S_DVW;
      end
      S_DVW: begin
        if (dv_done) begin
          if (cnt_r == 2'd2) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DVS;
            cnt_nxt   = cnt_r + 2'd1;
          end
        end
      end
      S_FIN: begin
        cnt_nxt   = 2'd0;
        state_nxt = is_read_r ? S_OUT : S_ARD;
      end
      S_ARD: state_nxt = S_AWR;
      S_AWR: begin
        if (cnt_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ARD;
          cnt_nxt   = cnt_r + 2'd1;
        end
      end
      S_RRD: state_nxt = S_RLD;
      S_RLD: begin
        state_nxt   = S_S3;
        sq_mode_nxt = 1'b1;
        cnt_nxt     = 2'd0;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      cnt_r       <= '0;
      sq_mode_r   <= 1'b0;
      is_read_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      sq_mode_r   <= sq_mode_nxt;
      is_read_r   <= is_read_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Memory addressing and write data.
  always_comb begin
    case (state_r)
      S_TA:    vaddr = a_r;
      S_TB:    vaddr = b_r;
      default: vaddr = c_r;
    endcase
  end

  assign saddr = (state_r == S_RRD) ? a_r : corner;

  assign vwdata = '{pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                    nrm_x: in_nrm_x, nrm_y: in_nrm_y, nrm_z: in_nrm_z,
                    tex_u: in_tex_u, tex_v: in_tex_v};

  always_comb begin
    swe    = 1'b0;
    swdata = '0;
    if (in_xfer && in_action == ACT_LOAD) begin
      swe = 1'b1;
    end else if (state_r == S_AWR) begin
      swe    = 1'b1;
      swdata = {sat_add(srd_r[2*SUM_WIDTH +: SUM_WIDTH], o_r[2]),
                sat_add(srd_r[SUM_WIDTH +: SUM_WIDTH], o_r[1]),
                sat_add(srd_r[0 +: SUM_WIDTH], o_r[0])};
    end
  end

  // Vertex memory: written by a load, read one corner per cycle.
  always_ff @(posedge clk) begin
    if (in_xfer && in_action == ACT_LOAD) begin
      vmem[slot_of(in_corner_a)] <= vwdata;
    end
    vrd_r <= vmem[vaddr];
  end

  // Sum memory: cleared by a load, updated by the triangle's read-modify-write.
  always_ff @(posedge clk) begin
    if (swe) begin
      smem[(state_r == S_AWR) ? corner : slot_of(in_corner_a)] <= swdata;
    end
    srd_r <= smem[saddr];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          a_r <= slot_of(in_corner_a);
          b_r <= slot_of(in_corner_b);
          c_r <= slot_of(in_corner_c);
        end
      end
      S_TB: begin
        pa_r[0] <= vrd_r.pos_x;
        pa_r[1] <= vrd_r.pos_y;
        pa_r[2] <= vrd_r.pos_z;
        na_r[0] <= vrd_r.nrm_x;
        na_r[1] <= vrd_r.nrm_y;
        na_r[2] <= vrd_r.nrm_z;
        tua_r   <= vrd_r.tex_u;
        tva_r   <= vrd_r.tex_v;
      end
      S_TC: begin
        e1_r[0] <= EDGE_W'(vrd_r.pos_x) - EDGE_W'(pa_r[0]);
        e1_r[1] <= EDGE_W'(vrd_r.pos_y) - EDGE_W'(pa_r[1]);
        e1_r[2] <= EDGE_W'(vrd_r.pos_z) - EDGE_W'(pa_r[2]);
        du1_r   <= EDGE_W'(vrd_r.tex_u) - EDGE_W'(tua_r);
        dv1_r   <= EDGE_W'(vrd_r.tex_v) - EDGE_W'(tva_r);
      end
      S_TD: begin
        e2_r[0] <= EDGE_W'(vrd_r.pos_x) - EDGE_W'(pa_r[0]);
        e2_r[1] <= EDGE_W'(vrd_r.pos_y) - EDGE_W'(pa_r[1]);
        e2_r[2] <= EDGE_W'(vrd_r.pos_z) - EDGE_W'(pa_r[2]);
        du2_r   <= EDGE_W'(vrd_r.tex_u) - EDGE_W'(tua_r);
        dv2_r   <= EDGE_W'(vrd_r.tex_v) - EDGE_W'(tva_r);
      end
      S_PB: acc_r <= prod;
      S_PC: begin
        if (ph_r == 3'd0) begin
          neg_r <= diff[PROD_W-1];
        end else if (ph_r <= 3'd3) begin
          t_r[kp] <= neg_r ? -T_W'(diff) : T_W'(diff);
        end else begin
          vec_r[kp] <= VEC_W'(PROD_W'(t_r[kp]) - proj_rnd);
        end
      end
      S_SHIFT: begin
        if (t_big) begin
          t_r[0] <= t_r[0] >>> 1;
          t_r[1] <= t_r[1] >>> 1;
          t_r[2] <= t_r[2] >>> 1;
        end
      end
      S_S3: acc_r <= (cnt_r == 2'd0) ? '0 : total;
      S_S3E: begin
        if (sq_mode_r) begin
          sq_r <= total[SQ_W-1:0];
          if (total == '0) begin
            o_r[0] <= '0;
            o_r[1] <= '0;
            o_r[2] <= '0;
          end
        end else begin
          dot_r <= total[DOT_W-1:0];
        end
      end
      S_SQW: begin
        if (sq_done) begin
          len_r <= sq_root;
        end
      end
      S_DVW: begin
        if (dv_done) begin
          o_r[cnt_r] <= dv_quot;
        end
      end
      S_RLD: begin
        vec_r[0] <= VEC_W'($signed(srd_r[0 +: SUM_WIDTH]));
        vec_r[1] <= VEC_W'($signed(srd_r[SUM_WIDTH +: SUM_WIDTH]));
        vec_r[2] <= VEC_W'($signed(srd_r[2*SUM_WIDTH +: SUM_WIDTH]));
      end
      S_OUT: begin
        if (out_free) begin
          out_slot_r   <= 10'(a_r);
          out_tan_r[0] <= o_r[0];
          out_tan_r[1] <= o_r[1];
          out_tan_r[2] <= o_r[2];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_slot_read = out_slot_r;
  assign out_tan_x     = out_tan_r[0];
  assign out_tan_y     = out_tan_r[1];
  assign out_tan_z     = out_tan_r[2];

  // Divider operands: magnitude and sign of the current component.
  assign dv_neg = vec_r[cnt_r][VEC_W-1];
  assign dv_mag = dv_neg ? VEC_W'(-(VEC_W+1)'(vec_r[cnt_r])) : VEC_W'(vec_r[cnt_r]);

  mta_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  mta_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  mta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .mag   (dv_mag),
    .neg   (dv_neg),
    .len   (len_r),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  // The root unit only finishes while the sequencer waits for it.
  `MTA_ASSERT_IMP(a_sqrt_done_wait, clk, rst_n, sq_done, state_r == S_SQW)
  // Each divider result is taken and the sequencer moves on.
  `MTA_ASSERT_NXT(a_div_done_step, clk, rst_n, dv_done && state_r == S_DVW, state_r == S_DVS || state_r == S_FIN)
  // The shift loop leaves every edge term inside 25 signed bits before the dot product.
  `MTA_ASSERT_IMP(a_t_bounded, clk, rst_n, state_r == S_S3 && !sq_mode_r, !t_big)

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the mesh tangent accumulator: random and directed loads,
// triangles and reads, with a bit-exact tangent predictor and a result scoreboard.
module testbench
  import mta_pkg::*;
();

  localparam int SLOTS     = 1024;
  localparam int SUM_W     = 24;
  localparam int CYCLE_CAP = 1500000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [1:0] act;
    logic [9:0] a;
    logic [9:0] b;
    logic [9:0] c;
    vtx_t       v;
  } mesh_op_t;

  typedef struct {
    logic [9:0]        slot;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
  } tangent_t;

  // Shadow copy of the vertex and sum memories, plus the tangents still owed by reads.
  class tangent_board;
    longint   pos[SLOTS][3];
    longint   nrm[SLOTS][3];
    longint   tex[SLOTS][2];
    longint   acc[SLOTS][3];
    tangent_t owed[$];
    int       errors;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Scales a vector to Q2.14 unit length; the zero vector stays zero.
    function void unitize(input longint v[3], output longint o[3]);
      longint unsigned sq, len, m, q;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        m = (v[k] < 0) ? -v[k] : v[k];
        sq += m * m;
      end
      if (sq == 0) begin
        for (int k = 0; k < 3; k++) o[k] = 0;
        return;
      end
      len = int_root(sq);
      for (int k = 0; k < 3; k++) begin
        m = ((v[k] < 0) ? -v[k] : v[k]) * Q14_ONE;
        q = (m + len / 2) / len;
        if (q > Q14_ONE) q = Q14_ONE;
        o[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
      end
    endfunction

    function void accumulate(int s, longint d[3]);
      longint hi, lo, r;
      hi = (64'sd1 <<< (SUM_W - 1)) - 1;
      lo = -hi - 1;
      for (int k = 0; k < 3; k++) begin
        r = acc[s][k] + d[k];
        acc[s][k] = (r > hi) ? hi : (r < lo) ? lo : r;
      end
    endfunction

    function void triangle(int a, int b, int c);
      longint du1, dv1, du2, dv2, det, dot, e1, e2, p;
      longint t[3];
      longint u[3];
      longint o[3];
      bit     flip, big;
      du1 = tex[b][0] - tex[a][0];
      dv1 = tex[b][1] - tex[a][1];
      du2 = tex[c][0] - tex[a][0];
      dv2 = tex[c][1] - tex[a][1];
      det = du1 * dv2 - du2 * dv1;
      // A negative UV determinant flips the sign of the edge combination.
      flip = (det < 0) && (-det <= 64'sd268435456000000);
      for (int k = 0; k < 3; k++) begin
        e1 = pos[b][k] - pos[a][k];
        e2 = pos[c][k] - pos[a][k];
        t[k] = e1 * dv2 - e2 * dv1;
        if (flip) t[k] = -t[k];
      end
      big = 1;
      while (big) begin
        big = 0;
        for (int k = 0; k < 3; k++)
          if (t[k] >= (64'sd1 <<< 24) || t[k] <= -(64'sd1 <<< 24)) big = 1;
        if (big)
          for (int k = 0; k < 3; k++) t[k] = t[k] >>> 1;
      end
      dot = 0;
      for (int k = 0; k < 3; k++) dot += t[k] * nrm[a][k];
      for (int k = 0; k < 3; k++) begin
        p = nrm[a][k] * dot;
        u[k] = t[k] - ((p + (64'sd1 <<< 27)) >>> 28);
      end
      unitize(u, o);
      accumulate(a, o);
      accumulate(b, o);
      accumulate(c, o);
    endfunction

    function void note(mesh_op_t op);
      longint   s[3];
      longint   o[3];
      tangent_t r;
      case (op.act)
        ACT_LOAD: begin
          pos[op.a][0] = op.v.pos_x; pos[op.a][1] = op.v.pos_y; pos[op.a][2] = op.v.pos_z;
          nrm[op.a][0] = op.v.nrm_x; nrm[op.a][1] = op.v.nrm_y; nrm[op.a][2] = op.v.nrm_z;
          tex[op.a][0] = op.v.tex_u; tex[op.a][1] = op.v.tex_v;
          for (int k = 0; k < 3; k++) acc[op.a][k] = 0;
        end
        ACT_TRI: triangle(op.a, op.b, op.c);
        ACT_READ: begin
          for (int k = 0; k < 3; k++) s[k] = acc[op.a][k];
          unitize(s, o);
          r.slot = op.a;
          r.tx = o[0][15:0];
          r.ty = o[1][15:0];
          r.tz = o[2][15:0];
          owed.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task check(tangent_t got);
      tangent_t w;
      if (owed.size() == 0) begin
        report($sformatf("unexpected tangent for slot %0d", got.slot));
        return;
      end
      w = owed.pop_front();
      if (got.slot !== w.slot)
        report($sformatf("slot %0d, expected %0d", got.slot, w.slot));
      if (got.tx !== w.tx)
        report($sformatf("slot %0d tan_x %0d, expected %0d", w.slot, got.tx, w.tx));
      if (got.ty !== w.ty)
        report($sformatf("slot %0d tan_y %0d, expected %0d", w.slot, got.ty, w.ty));
      if (got.tz !== w.tz)
        report($sformatf("slot %0d tan_z %0d, expected %0d", w.slot, got.tz, w.tz));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_action;
  logic [9:0]         in_corner_a, in_corner_b, in_corner_c;
  logic signed [15:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [15:0] in_nrm_x, in_nrm_y, in_nrm_z;
  logic signed [15:0] in_tex_u, in_tex_v;
  logic               out_valid;
  logic               out_ready;
  logic [9:0]         out_slot_read;
  logic signed [15:0] out_tan_x, out_tan_y, out_tan_z;

  tangent_board board = new();
  int           loaded_slots[$];
  bit           slot_loaded[SLOTS];
  logic         calm;
  int           stall_left;
  int           cycles = 0;

  mesh_tangent_accumulator uut (.*);

  always #10 clk = ~clk;

  // Presents one item, waits for its transfer and then maybe leaves a random gap.
  task automatic send(mesh_op_t op);
    in_valid    <= 1'b1;
    in_action   <= op.act;
    in_corner_a <= op.a;
    in_corner_b <= op.b;
    in_corner_c <= op.c;
    in_pos_x    <= op.v.pos_x;
    in_pos_y    <= op.v.pos_y;
    in_pos_z    <= op.v.pos_z;
    in_nrm_x    <= op.v.nrm_x;
    in_nrm_y    <= op.v.nrm_y;
    in_nrm_z    <= op.v.nrm_z;
    in_tex_u    <= op.v.tex_u;
    in_tex_v    <= op.v.tex_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note(op);
    if (op.act == ACT_LOAD && !slot_loaded[op.a]) begin
      slot_loaded[op.a] = 1;
      loaded_slots.push_back(op.a);
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic vtx_t noise_vertex();
    vtx_t v;
    v = {$urandom(), $urandom(), $urandom(), $urandom()};
    return v;
  endfunction

  function automatic mesh_op_t make_op(logic [1:0] act, int a, int b, int c, vtx_t v);
    mesh_op_t op;
    op.act = act;
    op.a = a;
    op.b = b;
    op.c = c;
    op.v = v;
    return op;
  endfunction

  task automatic load(int slot, vtx_t v);
    send(make_op(ACT_LOAD, slot, $urandom_range(0, 1023), $urandom_range(0, 1023), v));
  endtask

  task automatic tri_op(int a, int b, int c);
    send(make_op(ACT_TRI, a, b, c, noise_vertex()));
  endtask

  task automatic read(int slot);
    send(make_op(ACT_READ, slot, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 noise_vertex()));
  endtask

  function automatic int any_loaded();
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
  endfunction

  // Receiver side: checks every result transfer and stalls in random bursts until the
  // final stretch of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready)
        board.check('{out_slot_read, out_tan_x, out_tan_y, out_tan_z});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 7);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    vtx_t v;
    int   a, b, r;
    calm        = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_LOAD;
    in_corner_a = '0;
    in_corner_b = '0;
    in_corner_c = '0;
    {in_pos_x, in_pos_y, in_pos_z, in_nrm_x, in_nrm_y, in_nrm_z, in_tex_u, in_tex_v} = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, every action, repeated corners, a zero UV
    // determinant, an untouched sum read back as zero and the ignored action.
    load(0, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh8000});
    load(1023, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh7fff, 16'sh7fff});
    load(1, '{16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000,
              16'sh4000, 16'sh0000});
    load(2, '{16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000,
              16'sh0000, 16'sh4000});
    load(3, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000,
              16'sh0000, 16'sh0000});
    read(3);
    tri_op(3, 1, 2);
    tri_op(3, 2, 1);
    read(3);
    read(1);
    tri_op(0, 1023, 1);
    tri_op(1023, 0, 2);
    tri_op(1, 1, 2);
    read(0);
    read(1023);
    read(1);
    load(4, '{16'sh0300, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000,
              16'sh2000, 16'sh2000});
    tri_op(4, 4, 4);
    tri_op(3, 4, 4);
    read(4);
    send(make_op(ACT_NONE, 1, 2, 3, noise_vertex()));
    read(2);

    // Pile one tangent direction onto the same three sums, then read two of them back.
    repeat (20) tri_op(3, 1, 2);
    read(3);
    read(2);

    // Random part: mostly small slot numbers so triangles share vertices.
    for (int n = 0; n < 370; n++) begin
      if (n == 310) calm <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 28) begin
        a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        v = noise_vertex();
        if ($urandom_range(0, 2) == 0) v.nrm_z = 16'sh4000;
        load(a, v);
      end else if (r < 73) begin
        a = any_loaded();
        b = any_loaded();
        tri_op(a, b, ($urandom_range(0, 7) == 0) ? a : any_loaded());
      end else if (r < 97) begin
        read(any_loaded());
      end else begin
        send(make_op(ACT_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), noise_vertex()));
      end
    end
    in_valid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mta_pkg.sv
rtl/core/mta_mul.sv
rtl/core/mta_sqrt.sv
rtl/core/mta_div.sv
rtl/core/mesh_tangent_accumulator.sv
test/testbench.sv
